/* design/source_attempt_blocker_macros.svh */
// Assertion macros for the source attempt blocker
`ifndef SOURCE_ATTEMPT_BLOCKER_MACROS_SVH
`define SOURCE_ATTEMPT_BLOCKER_MACROS_SVH

// condition holds in the same cycle as its trigger
`define SAB_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after its trigger
`define SAB_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* design/sab_pkg.sv */
// Types and constants shared by the source attempt blocker files
`timescale 1ns / 1ps
package sab_pkg;
	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int USED_W = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W = 32;
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] THRESH_RESET = 8'd2;

	typedef logic [ADDR_W-1:0] src_addr_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [USED_W-1:0] used_t;

	typedef enum logic [2:0] {
		ST_ALREADY   = 3'd0,
		ST_NEWLY     = 3'd1,
		ST_COUNTED   = 3'd2,
		ST_NEW_ENTRY = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		src_addr_t addr;
		count_t    count;
	} entry_t;
endpackage

/* design/sab_ifs.sv */
// Valid/ready channel interfaces for attempts and results
`timescale 1ns / 1ps
interface sab_attempt_if;
	logic                valid;
	logic                ready;
	sab_pkg::src_addr_t  source_addr;

	modport source (output valid, output source_addr, input ready);
	modport sink (input valid, input source_addr, output ready);
endinterface

interface sab_result_if;
	logic              valid;
	logic              ready;
	sab_pkg::status_t  status;
	sab_pkg::count_t   attempt_count;

	modport source (output valid, output status, output attempt_count, input ready);
	modport sink (input valid, input status, input attempt_count, output ready);
endinterface

/* design/sab_ram.sv */
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module sab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/source_attempt_blocker.sv */
// Per-source failed-attempt blocklist: top level with scan sequencer
// The result follows the attempt after a linear scan through the table RAM, one read per cycle
// on its single read port; the output register can hold it back while the result channel stalls.
// A new attempt is accepted only in idle, once the previous result has moved to the output register.
// Reset: asynchronous, clears the sequencer, output valid and entry count, threshold to 2;
// the table RAM is not cleared, entries beyond the count are never read.
`timescale 1ns / 1ps
`include "source_attempt_blocker_macros.svh"
module source_attempt_blocker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  sab_pkg::count_t      cfg_wdata,
	sab_attempt_if.sink          attempt,
	sab_result_if.source         result
);
	import sab_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t    state_q;
	count_t    thresh_q;
	used_t     used_q;
	used_t     idx_q;
	logic      pend_q;
	src_addr_t addr_q;
	status_t   res_status_q;
	count_t    res_count_q;
	logic      out_valid_q;
	status_t   out_status_q;
	count_t    out_count_q;

	idx_t      rd_idx_q;
	entry_t    rd_entry;
	logic      hit;
	logic      scan_end;
	logic      issue;
	logic      ram_we;
	idx_t      ram_waddr;
	entry_t    ram_wdata;
	count_t    inc_count;
	logic      out_free;

	sab_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	assign attempt.ready        = (state_q == S_IDLE);
	assign result.valid         = out_valid_q;
	assign result.status        = out_status_q;
	assign result.attempt_count = out_count_q;

	assign hit       = (state_q == S_SCAN) && pend_q && (rd_entry.addr == addr_q);
	assign scan_end  = (state_q == S_SCAN) && !hit && (idx_q == used_q);
	assign issue     = (state_q == S_SCAN) && !hit && (idx_q != used_q);
	assign inc_count = rd_entry.count + count_t'(1);
	assign out_free  = !out_valid_q || result.ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_q;
		ram_wdata = '{addr: addr_q, count: inc_count};
		if (hit && (rd_entry.count < thresh_q)) begin
			ram_we = 1'b1;
		end else if (scan_end && (used_q != used_t'(TABLE_DEPTH))) begin
			ram_we    = 1'b1;
			ram_waddr = used_q[IDX_W-1:0];
			ram_wdata = '{addr: addr_q, count: count_t'(1)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (attempt.valid) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit || scan_end) begin
						pend_q  <= 1'b0;
						state_q <= S_DONE;
						if (scan_end && (used_q != used_t'(TABLE_DEPTH))) begin
							used_q <= used_q + used_t'(1);
						end
					end else begin
						pend_q <= 1'b1;
						idx_q  <= idx_q + used_t'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (attempt.valid && attempt.ready) begin
			addr_q <= attempt.source_addr;
		end
		if (issue) begin
			rd_idx_q <= idx_q[IDX_W-1:0];
		end
		if (hit) begin
			if (rd_entry.count >= thresh_q) begin
				res_status_q <= ST_ALREADY;
				res_count_q  <= rd_entry.count;
			end else begin
				res_status_q <= (inc_count >= thresh_q) ? ST_NEWLY : ST_COUNTED;
				res_count_q  <= inc_count;
			end
		end else if (scan_end) begin
			if (used_q == used_t'(TABLE_DEPTH)) begin
				res_status_q <= ST_FULL;
				res_count_q  <= '0;
			end else begin
				res_status_q <= ST_NEW_ENTRY;
				res_count_q  <= count_t'(1);
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			out_status_q <= res_status_q;
			out_count_q  <= res_count_q;
		end
	end

	`SAB_ASSERT_SAME(a_used_bound, 1'b1, used_q <= used_t'(TABLE_DEPTH), "entry count beyond table depth")
	`SAB_ASSERT_SAME(a_we_in_scan, ram_we, state_q == S_SCAN, "table written outside scan")
	`SAB_ASSERT_NEXT(a_start_scan, attempt.valid && attempt.ready, (state_q == S_SCAN) && (idx_q == '0) && !pend_q, "scan did not start from entry zero")
	`SAB_ASSERT_SAME(a_full_zero, out_valid_q && (out_status_q == ST_FULL), out_count_q == '0, "table full result with nonzero count")
endmodule

/* tb/source_attempt_blocker_checker.sv */
// Checker for the source attempt blocker: predicts each verdict and compares it with the result
`timescale 1ns / 1ps
module source_attempt_blocker_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  sab_pkg::count_t  cfg_wdata,
	sab_attempt_if           attempt,
	sab_result_if            result,
	output int               fail_count,
	output int               results_seen,
	output int               verdicts_left
);
	import sab_pkg::*;

	typedef struct {
		status_t status;
		count_t  attempt_count;
	} verdict_t;

	src_addr_t tracked_addr [TABLE_DEPTH];
	count_t    tracked_count [TABLE_DEPTH];
	int        tracked_used;
	count_t    threshold_now;
	verdict_t  awaited_verdicts [$];

	function automatic verdict_t judge_attempt(input src_addr_t addr);
		verdict_t v;
		int hit;
		count_t c;
		hit = -1;
		for (int i = 0; i < tracked_used; i++) begin
			if (hit < 0 && tracked_addr[i] == addr)
				hit = i;
		end
		if (hit >= 0) begin
			c = tracked_count[hit];
			if (c >= threshold_now) begin
				v.status = ST_ALREADY;
				v.attempt_count = c;
			end else begin
				c = c + 8'd1;
				tracked_count[hit] = c;
				v.status = (c >= threshold_now) ? ST_NEWLY : ST_COUNTED;
				v.attempt_count = c;
			end
		end else if (tracked_used >= TABLE_DEPTH) begin
			v.status = ST_FULL;
			v.attempt_count = '0;
		end else begin
			tracked_addr[tracked_used] = addr;
			tracked_count[tracked_used] = 8'd1;
			tracked_used++;
			v.status = ST_NEW_ENTRY;
			v.attempt_count = 8'd1;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			tracked_used = 0;
			threshold_now = THRESH_RESET;
			awaited_verdicts.delete();
			fail_count = 0;
			results_seen = 0;
			verdicts_left = 0;
		end else begin
			if (cfg_we)
				threshold_now = cfg_wdata;
			if (result.valid && result.ready) begin
				results_seen++;
				if (awaited_verdicts.size() == 0) begin
					$error("result with no attempt waiting: status %0d, attempt_count %0d",
						result.status, result.attempt_count);
					fail_count++;
				end else begin
					want = awaited_verdicts.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
					if (result.attempt_count !== want.attempt_count) begin
						$error("attempt_count: expected %0d, got %0d",
							want.attempt_count, result.attempt_count);
						fail_count++;
					end
				end
			end
			if (attempt.valid && attempt.ready)
				awaited_verdicts.push_back(judge_attempt(attempt.source_addr));
			verdicts_left = awaited_verdicts.size();
		end
	end
endmodule

/* tb/source_attempt_blocker_test.sv */
// Testbench top for the source attempt blocker: stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps
module source_attempt_blocker_test;
	import sab_pkg::*;

	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	count_t cfg_wdata;
	int     fail_count;
	int     results_seen;
	int     verdicts_left;
	int     attempts_sent = 0;
	int     settings_used = 1;
	int     stall_run = 0;
	bit     hold_off_req = 1'b0;
	bit     hold_off_served = 1'b0;
	src_addr_t known_sources [$];

	sab_attempt_if attempt_ch ();
	sab_result_if  result_ch ();

	source_attempt_blocker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.attempt   (attempt_ch),
		.result    (result_ch)
	);

	source_attempt_blocker_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.attempt       (attempt_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.results_seen  (results_seen),
		.verdicts_left (verdicts_left)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic bit is_known(input src_addr_t addr);
		foreach (known_sources[i]) begin
			if (known_sources[i] == addr)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic src_addr_t known_or_fresh(input int pct_fresh);
		src_addr_t a;
		if (known_sources.size() == 0 || $urandom_range(0, 99) < pct_fresh) begin
			do
				a = $urandom;
			while (is_known(a));
			return a;
		end
		return known_sources[$urandom_range(0, known_sources.size() - 1)];
	endfunction

	task automatic offer_attempt(input src_addr_t addr, input int gap);
		attempt_ch.valid <= 1'b1;
		attempt_ch.source_addr <= addr;
		do
			@(posedge clk);
		while (!attempt_ch.ready);
		attempts_sent++;
		if (!is_known(addr))
			known_sources.push_back(addr);
		if (gap > 0) begin
			attempt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_mix(input int n, input int pct_fresh, input bit back_to_back);
		for (int k = 0; k < n; k++)
			offer_attempt(known_or_fresh(pct_fresh), back_to_back ? 0 : pick_gap());
	endtask

	task automatic settle();
		attempt_ch.valid <= 1'b0;
		while (results_seen != attempts_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_threshold(input count_t value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int on_len;
		int off_len;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_served) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_served = 1'b1;
			end
			on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			result_ch.ready <= 1'b1;
			repeat (on_len) @(posedge clk);
			off_len = pick_gap();
			if (off_len > 0) begin
				result_ch.ready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((attempt_ch.valid && attempt_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_run <= 0;
		else
			stall_run <= stall_run + 1;
		if (stall_run >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		count_t wide_thr [4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		attempt_ch.valid = 1'b0;
		attempt_ch.source_addr = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold: new, newly blocked, already blocked
		offer_attempt(32'h0000_0000, pick_gap());
		offer_attempt(32'h0000_0000, pick_gap());
		offer_attempt(32'h0000_0000, pick_gap());
		offer_attempt(32'hFFFF_FFFF, pick_gap());
		settle();
		set_threshold(8'd3);
		offer_attempt(32'hFFFF_FFFF, pick_gap());
		offer_attempt(32'hFFFF_FFFF, pick_gap());
		offer_attempt(32'hFFFF_FFFF, pick_gap());
		settle();
		// zero threshold: tracked sources always blocked, new ones still appended
		set_threshold(8'd0);
		offer_attempt(32'h0000_0000, pick_gap());
		offer_attempt(32'h8000_0001, pick_gap());
		offer_attempt(32'h8000_0001, pick_gap());
		settle();
		set_threshold(8'd1);
		offer_attempt(32'h7FFF_FFFE, pick_gap());
		offer_attempt(32'h7FFF_FFFE, pick_gap());
		settle();
		set_threshold(8'd255);
		offer_attempt(32'h0000_0000, pick_gap());

		for (int p = 0; p < 5; p++) begin
			settle();
			set_threshold(count_t'($urandom_range(2, 10)));
			run_mix(100, 25, 1'b0);
		end

		// drive one source up to the top count, then past it
		settle();
		set_threshold(8'd255);
		for (int k = 0; k < 300; k++)
			offer_attempt((k % 8 == 7) ? known_or_fresh(0) : known_sources[0], pick_gap());

		// fill the table and run on into table-full
		wide_thr[0] = count_t'($urandom_range(1, 6));
		wide_thr[1] = 8'd1;
		wide_thr[2] = count_t'($urandom_range(2, 255));
		wide_thr[3] = 8'd255;
		for (int p = 0; p < 4; p++) begin
			settle();
			set_threshold(wide_thr[p]);
			run_mix(112, 35, 1'b0);
		end

		settle();
		set_threshold(8'd0);
		run_mix(100, 30, 1'b0);

		// hold results back while attempts keep coming
		settle();
		set_threshold(count_t'($urandom_range(2, 5)));
		hold_off_req = 1'b1;
		run_mix(30, 50, 1'b1);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d attempts from %0d distinct sources under %0d threshold settings,",
			attempts_sent, known_sources.size(), settings_used);
		$display("with %0d results checked and one receiver hold-off of %0d cycles.",
			results_seen, HOLD_OFF_CYCLES);
		if (fail_count == 0 && verdicts_left == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
